/* rtl/mbrr_pkg.sv */
// Shared constants, codes and the CRC-16 byte step for the Modbus read master.
// No dependencies; imported by the channel interfaces and the top level.
package mbrr_pkg;

    localparam int unsigned ADDR_W   = 8;
    localparam int unsigned REG_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // input actions
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_RX_BYTE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_HEADER  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [ADDR_W-1:0] SLAVE_ADDRESS_RST = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd200;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] REPLY_BYTE_COUNT  = 8'h02;
    localparam logic [7:0] REG_COUNT_HI      = 8'h00;
    localparam logic [7:0] REG_COUNT_LO      = 8'h01;

    // reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/mbrr_in_if.sv */
// Input channel: valid/ready handshake carrying one action beat.
// Depends on mbrr_pkg.
interface mbrr_in_if;
    import mbrr_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [REG_W-1:0]  reg_address;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, action, reg_address, rx_byte, input ready);
    modport sink   (input valid, action, reg_address, rx_byte, output ready);
endinterface

/* rtl/mbrr_out_if.sv */
// Result channel: valid/ready handshake carrying one transmit or status beat.
// Depends on mbrr_pkg.
interface mbrr_out_if;
    import mbrr_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic [REG_W-1:0]  read_value;
    logic [1:0]        status;

    modport source (output valid, kind, tx_byte, last, read_value, status, input ready);
    modport sink   (input valid, kind, tx_byte, last, read_value, status, output ready);
endinterface

/* rtl/modbus_read_register_master.sv */
// Modbus RTU master for a single holding-register read (function 3, count 1).
// Depends on mbrr_pkg, mbrr_in_if and mbrr_out_if.
//
//   channel   dir  handshake      beat contents
//   i_in      in   valid/ready    action, reg_address, rx_byte
//   o_out     out  valid/ready    kind, tx_byte, last, read_value, status
//   i_cfg_*   in   write enable   register index, write data
//
// Received bytes and ticks are taken one per cycle unless a request burst runs
// or the output stalls; each passes the reply checker combinationally and any
// status lands in the single output register. A start beat is latched, then
// eight request bytes with their CRC go out, one per cycle unless stalled.
// A stalled output holds its beat and blocks further input beats.
// Reset is synchronous, active low; it leaves the block idle.
module modbus_read_register_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbrr_in_if.sink                          i_in,
    mbrr_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [mbrr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbrr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mbrr_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_slave_address;
    logic [TICK_W-1:0] r_timeout_ticks;

    // reply tracking
    logic              r_waiting,      n_waiting;
    logic [2:0]        r_reply_count,  n_reply_count;
    logic [15:0]       r_running_crc,  n_running_crc;
    logic              r_header_bad,   n_header_bad;
    logic [REG_W-1:0]  r_reply_value,  n_reply_value;
    logic [7:0]        r_crc_low_byte, n_crc_low_byte;
    logic [TICK_W-1:0] r_elapsed,      n_elapsed;

    // request burst
    logic              r_burst_active, n_burst_active;
    logic [2:0]        r_burst_idx,    n_burst_idx;
    logic [REG_W-1:0]  r_req_addr,     n_req_addr;
    logic [15:0]       r_tx_crc,       n_tx_crc;

    // output register
    logic              r_out_valid,    n_out_valid;
    logic              r_out_kind,     n_out_kind;
    logic [BYTE_W-1:0] r_out_tx,       n_out_tx;
    logic              r_out_last,     n_out_last;
    logic [REG_W-1:0]  r_out_value,    n_out_value;
    logic [1:0]        r_out_status,   n_out_status;

    logic              w_slot_free;
    logic              w_in_fire;
    logic [7:0]        w_tx_byte;
    logic [15:0]       w_crc_rx;
    logic [15:0]       w_crc_tx;
    logic [15:0]       w_got_crc;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_burst_active && w_slot_free;
    assign w_in_fire   = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.tx_byte    = r_out_tx;
    assign o_out.last       = r_out_last;
    assign o_out.read_value = r_out_value;
    assign o_out.status     = r_out_status;

    always_comb begin
        case (r_burst_idx)
            3'd0:    w_tx_byte = r_slave_address;
            3'd1:    w_tx_byte = FUNC_READ_HOLDING;
            3'd2:    w_tx_byte = r_req_addr[15:8];
            3'd3:    w_tx_byte = r_req_addr[7:0];
            3'd4:    w_tx_byte = REG_COUNT_HI;
            3'd5:    w_tx_byte = REG_COUNT_LO;
            3'd6:    w_tx_byte = r_tx_crc[7:0];
            default: w_tx_byte = r_tx_crc[15:8];
        endcase
    end

    assign w_crc_tx  = crc16_feed(r_tx_crc, w_tx_byte);
    assign w_crc_rx  = crc16_feed(r_running_crc, i_in.rx_byte);
    assign w_got_crc = {i_in.rx_byte, r_crc_low_byte};

    always_comb begin
        n_waiting      = r_waiting;
        n_reply_count  = r_reply_count;
        n_running_crc  = r_running_crc;
        n_header_bad   = r_header_bad;
        n_reply_value  = r_reply_value;
        n_crc_low_byte = r_crc_low_byte;
        n_elapsed      = r_elapsed;
        n_burst_active = r_burst_active;
        n_burst_idx    = r_burst_idx;
        n_req_addr     = r_req_addr;
        n_tx_crc       = r_tx_crc;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_kind     = r_out_kind;
        n_out_tx       = r_out_tx;
        n_out_last     = r_out_last;
        n_out_value    = r_out_value;
        n_out_status   = r_out_status;

        if (r_burst_active && w_slot_free) begin
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_TX;
            n_out_tx     = w_tx_byte;
            n_out_last   = (r_burst_idx == 3'd7);
            n_out_value  = '0;
            n_out_status = ST_OK;
            if (r_burst_idx < 3'd6) begin
                n_tx_crc = w_crc_tx;
            end
            if (r_burst_idx == 3'd7) begin
                n_burst_active = 1'b0;
            end
            n_burst_idx = r_burst_idx + 3'd1;
        end

        if (w_in_fire) begin
            case (i_in.action)
                ACT_START: begin
                    n_waiting      = 1'b1;
                    n_reply_count  = '0;
                    n_running_crc  = CRC_SEED;
                    n_header_bad   = 1'b0;
                    n_reply_value  = '0;
                    n_crc_low_byte = '0;
                    n_elapsed      = '0;
                    n_burst_active = 1'b1;
                    n_burst_idx    = '0;
                    n_req_addr     = i_in.reg_address;
                    n_tx_crc       = CRC_SEED;
                end
                ACT_RX_BYTE: begin
                    if (r_waiting) begin
                        case (r_reply_count)
                            3'd0: begin
                                if (i_in.rx_byte != r_slave_address) n_header_bad = 1'b1;
                            end
                            3'd1: begin
                                if (i_in.rx_byte != FUNC_READ_HOLDING) n_header_bad = 1'b1;
                            end
                            3'd2: begin
                                if (i_in.rx_byte != REPLY_BYTE_COUNT) n_header_bad = 1'b1;
                            end
                            3'd3:    n_reply_value = {i_in.rx_byte, 8'h00};
                            3'd4:    n_reply_value = {r_reply_value[15:8], i_in.rx_byte};
                            3'd5:    n_crc_low_byte = i_in.rx_byte;
                            default: ;
                        endcase
                        if (r_reply_count < 3'd5) begin
                            n_running_crc = w_crc_rx;
                        end
                        if (r_reply_count < 3'd6) begin
                            n_reply_count = r_reply_count + 3'd1;
                        end else begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_DONE;
                            n_out_tx     = '0;
                            n_out_last   = 1'b1;
                            n_out_value  = '0;
                            if (r_header_bad) begin
                                n_out_status = ST_HEADER;
                            end else if (w_got_crc != r_running_crc) begin
                                n_out_status = ST_CRC;
                            end else begin
                                n_out_status = ST_OK;
                                n_out_value  = r_reply_value;
                            end
                            n_waiting     = 1'b0;
                            n_reply_count = '0;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_waiting) begin
                        if (r_elapsed >= r_timeout_ticks) begin
                            n_out_valid   = 1'b1;
                            n_out_kind    = KIND_DONE;
                            n_out_tx      = '0;
                            n_out_last    = 1'b1;
                            n_out_value   = '0;
                            n_out_status  = ST_TIMEOUT;
                            n_waiting     = 1'b0;
                            n_reply_count = '0;
                        end else begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= SLAVE_ADDRESS_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
            r_waiting       <= 1'b0;
            r_reply_count   <= '0;
            r_running_crc   <= CRC_SEED;
            r_header_bad    <= 1'b0;
            r_elapsed       <= '0;
            r_burst_active  <= 1'b0;
            r_burst_idx     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg_data[ADDR_W-1:0];
                    CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            r_waiting      <= n_waiting;
            r_reply_count  <= n_reply_count;
            r_running_crc  <= n_running_crc;
            r_header_bad   <= n_header_bad;
            r_elapsed      <= n_elapsed;
            r_burst_active <= n_burst_active;
            r_burst_idx    <= n_burst_idx;
            r_out_valid    <= n_out_valid;
        end
        r_reply_value  <= n_reply_value;
        r_crc_low_byte <= n_crc_low_byte;
        r_req_addr     <= n_req_addr;
        r_tx_crc       <= n_tx_crc;
        r_out_kind     <= n_out_kind;
        r_out_tx       <= n_out_tx;
        r_out_last     <= n_out_last;
        r_out_value    <= n_out_value;
        r_out_status   <= n_out_status;
    end

    a_start_opens_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.action == ACT_START)
        |=> (r_burst_active && r_burst_idx == 3'd0 && r_waiting))
        else $error("start beat did not open a request burst");

    a_burst_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_active && w_slot_free && r_burst_idx == 3'd7)
        |=> (!r_burst_active && r_out_valid && r_out_last && r_out_kind == KIND_TX))
        else $error("request burst did not close on its last byte");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_DONE) |-> r_out_last)
        else $error("status beat without last");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_waiting |-> (r_reply_count == 3'd0))
        else $error("reply count left over while idle");

    a_status_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_value == '0))
        else $error("read value on a failed read");

endmodule
